/* rtl/core/lrp_pkg.sv */
// Shared constants, widths and tables for the lidar ray to pixel projection block.
`timescale 1ns / 1ps

package lrp_pkg;

	// field widths
	localparam int RANGE_W    = 16;
	localparam int ANGLE_W    = 16;
	localparam int PPM_W      = 24;
	localparam int PIX_W      = 9;
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;

	// image geometry
	localparam int IMAGE_SIZE = 512;
	localparam int IMAGE_HALF = IMAGE_SIZE / 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PPM       = 3'd4;

	localparam logic [RANGE_W-1:0] RST_MIN_RANGE = 16'd120;
	localparam logic [RANGE_W-1:0] RST_MAX_RANGE = 16'd3500;
	localparam logic [ANGLE_W-1:0] RST_START_ANG = 16'd0;
	localparam logic [ANGLE_W-1:0] RST_ANG_STEP  = 16'd182;
	localparam logic [PPM_W-1:0]   RST_PPM       = 24'd74898;

	// digit-serial multiplier: parallel multiplicand, multiplier in 4 bit digits
	localparam int MUL_A_W   = 40;
	localparam int MUL_B_W   = 24;
	localparam int MUL_DIG_W = 4;
	localparam int MUL_NDIG  = MUL_B_W / MUL_DIG_W;
	localparam int MUL_CNT_W = $clog2(MUL_NDIG);
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

	// CORDIC datapath, Q30 vector and binary angle units
	localparam int CORDIC_ITERS = 16;
	localparam int ITER_W       = $clog2(CORDIC_ITERS);
	localparam int XY_W         = 33;
	localparam int Z_W          = 18;

	localparam logic signed [XY_W-1:0] CORDIC_K     = XY_W'(652032874);
	localparam logic signed [Z_W-1:0]  QUARTER_TURN = Z_W'(16384);
	localparam logic signed [Z_W-1:0]  HALF_TURN    = Z_W'(32768);

	// Q30 to Q20, then integer part of the Q40 product
	localparam int FRAC_DROP = 10;
	localparam int MAG_W     = XY_W - FRAC_DROP;
	localparam int IP_LSB    = 40;
	localparam int IP_W      = MUL_P_W - IP_LSB;

	// arctangent of 2^-i in binary angle units
	function automatic logic signed [Z_W-1:0] atan_bam(input logic [ITER_W-1:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			4'd0:    v = Z_W'(8192);
			4'd1:    v = Z_W'(4836);
			4'd2:    v = Z_W'(2555);
			4'd3:    v = Z_W'(1297);
			4'd4:    v = Z_W'(651);
			4'd5:    v = Z_W'(326);
			4'd6:    v = Z_W'(163);
			4'd7:    v = Z_W'(81);
			4'd8:    v = Z_W'(41);
			4'd9:    v = Z_W'(20);
			4'd10:   v = Z_W'(10);
			4'd11:   v = Z_W'(5);
			4'd12:   v = Z_W'(3);
			4'd13:   v = Z_W'(1);
			4'd14:   v = Z_W'(1);
			default: v = Z_W'(0);
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/lidar_ray_to_pixel_projection.sv */
// Top level: ray angle tracking, range gate, CORDIC and digit-serial scaling to pixels.
`timescale 1ns / 1ps

// One range reading per input beat becomes one pixel beat. A reading that passes the
// gate (finite, strictly between min_range_mm and max_range_mm) goes through 16 CORDIC
// iterations, during which range times pixels_per_mm runs through a digit-serial
// multiplier, then 6 digit steps for the two coordinate products side by side, then
// into the output register; no new reading is taken before that. A rejected reading
// goes straight to the output register. A finished beat waits in the output register
// while the next reading is taken. The ray angle restarts at start_angle on a beat with
// scan_start set, and otherwise steps by angle_step; before any scan start it counts
// from 0. Out-of-image and rejected rays come out with hit low and both coordinates 0.

module lidar_ray_to_pixel_projection (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lrp_pkg::CFG_DATA_W-1:0]     cfg_data,
	// ray input
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lrp_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] range_mm
	input  logic [lrp_pkg::IN_USER_W-1:0]      s_tuser,   // [0] range_finite, [1] scan_start
	// pixel output
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lrp_pkg::OUT_DATA_W-1:0]     m_tdata,   // [8:0] pixel_x, [17:9] pixel_y
	output logic                               m_tuser    // [0] hit
);
	import lrp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROT,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic                 gate_q;
	logic [ANGLE_W-1:0]   next_angle_q;
	logic [RANGE_W-1:0]   min_range_q;
	logic [RANGE_W-1:0]   max_range_q;
	logic [ANGLE_W-1:0]   start_angle_q;
	logic [ANGLE_W-1:0]   angle_step_q;
	logic [PPM_W-1:0]     ppm_q;

	logic                 accept;
	logic [RANGE_W-1:0]   range_in;
	logic                 gate_in;
	logic [ANGLE_W-1:0]   ray_angle;
	logic [ANGLE_W-1:0]   angle_sum;
	logic                 rot_start;
	logic                 xy_start;

	logic                   rot_done;
	logic signed [XY_W-1:0] cosine;
	logic signed [XY_W-1:0] sine;
	logic                   pmul_done;
	logic [MUL_P_W-1:0]     pmul_prod;
	logic                   xmul_done;
	logic [MUL_P_W-1:0]     xmul_prod;
	logic                   ymul_done;
	logic [MUL_P_W-1:0]     ymul_prod;

	logic signed [MAG_W-1:0] fx;
	logic signed [MAG_W-1:0] fy;
	logic                    negx;
	logic                    negy;
	logic [MAG_W-1:0]        magx;
	logic [MAG_W-1:0]        magy;
	logic [PIX_W:0]          placex;
	logic [PIX_W:0]          placey;
	logic                    res_hit;

	// signed integer offset plus half image; returns {inside, column}
	function automatic logic [PIX_W:0] place(input logic [IP_W-1:0] ip, input logic neg);
		logic signed [IP_W+1:0] ext;
		logic signed [IP_W+1:0] half;
		logic signed [IP_W+1:0] pos;
		logic                   ok;
		ext  = signed'({2'b00, ip});
		half = (IP_W+2)'(IMAGE_HALF);
		pos  = neg ? (half - ext) : (half + ext);
		ok   = !pos[IP_W+1] && (pos < (IP_W+2)'(IMAGE_SIZE));
		return {ok, pos[PIX_W-1:0]};
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign range_in  = s_tdata[RANGE_W-1:0];
	assign gate_in   = s_tuser[0] && (range_in > min_range_q) && (range_in < max_range_q);
	assign ray_angle = s_tuser[1] ? start_angle_q : next_angle_q;
	assign angle_sum = ray_angle + angle_step_q;
	assign rot_start = accept && gate_in;
	assign xy_start  = (state_q == ST_ROT) && rot_done && pmul_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q   <= RST_MIN_RANGE;
			max_range_q   <= RST_MAX_RANGE;
			start_angle_q <= RST_START_ANG;
			angle_step_q  <= RST_ANG_STEP;
			ppm_q         <= RST_PPM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_RANGE: min_range_q   <= cfg_data[RANGE_W-1:0];
				REG_MAX_RANGE: max_range_q   <= cfg_data[RANGE_W-1:0];
				REG_START_ANG: start_angle_q <= cfg_data[ANGLE_W-1:0];
				REG_ANG_STEP:  angle_step_q  <= cfg_data[ANGLE_W-1:0];
				REG_PPM:       ppm_q         <= cfg_data[PPM_W-1:0];
				default: ;
			endcase
		end
	end

	// rotation and pixel distance run side by side
	lrp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start),
		.angle  (ray_angle),
		.done   (rot_done),
		.cosine (cosine),
		.sine   (sine)
	);

	lrp_digit_mul u_pmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start),
		.a      (MUL_A_W'(ppm_q)),
		.b      (MUL_B_W'(range_in)),
		.done   (pmul_done),
		.prod   (pmul_prod)
	);

	// Q30 to Q20 by floor shift, then sign and magnitude
	assign fx   = MAG_W'(cosine >>> FRAC_DROP);
	assign fy   = MAG_W'(sine >>> FRAC_DROP);
	assign negx = fx[MAG_W-1];
	assign negy = fy[MAG_W-1];
	assign magx = negx ? (~fx + 1'b1) : fx;
	assign magy = negy ? (~fy + 1'b1) : fy;

	lrp_digit_mul u_xmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (xy_start),
		.a      (pmul_prod[MUL_A_W-1:0]),
		.b      (MUL_B_W'(magx)),
		.done   (xmul_done),
		.prod   (xmul_prod)
	);

	lrp_digit_mul u_ymul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (xy_start),
		.a      (pmul_prod[MUL_A_W-1:0]),
		.b      (MUL_B_W'(magy)),
		.done   (ymul_done),
		.prod   (ymul_prod)
	);

	// truncated integer parts placed around the image center
	assign placex  = place(xmul_prod[MUL_P_W-1:IP_LSB], negx);
	assign placey  = place(ymul_prod[MUL_P_W-1:IP_LSB], negy);
	assign res_hit = gate_q && placex[PIX_W] && placey[PIX_W];

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gate_q       <= 1'b0;
			next_angle_q <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= 1'b0;
		end else begin
			// a beat taken outside the load state empties the register
			if (m_tvalid && m_tready && state_q != ST_OUT) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						next_angle_q <= angle_sum;
						gate_q       <= gate_in;
						state_q      <= gate_in ? ST_ROT : ST_OUT;
					end
				end
				ST_ROT: begin
					if (xy_start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (xmul_done && ymul_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_hit;
						m_tdata  <= res_hit ?
							{{(OUT_DATA_W-2*PIX_W){1'b0}}, placey[PIX_W-1:0],
							 placex[PIX_W-1:0]} : '0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scaling only starts once both rotation and pixel distance are finished
	a_mul_after_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (rot_done && pmul_done))
		else $error("coordinate products running before rotation finished");

	// every accepted ray advances the angle
	a_angle_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (next_angle_q == $past(angle_sum)))
		else $error("ray angle did not advance on accept");

	// a ray that failed the gate never reports a hit
	a_reject_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !gate_q) |-> !res_hit)
		else $error("rejected ray reported as hit");

endmodule

/* rtl/core/lrp_digit_mul.sv */
// Digit-serial unsigned multiplier: one 4 bit digit of the multiplier per cycle.
`timescale 1ns / 1ps

module lrp_digit_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lrp_pkg::MUL_A_W-1:0]  a,
	input  logic [lrp_pkg::MUL_B_W-1:0]  b,
	output logic                         done,
	output logic [lrp_pkg::MUL_P_W-1:0]  prod
);
	import lrp_pkg::*;

	logic [MUL_A_W-1:0]           a_q;
	logic [MUL_A_W-1:0]           acc_q;
	logic [MUL_B_W-1:0]           b_q;
	logic [MUL_CNT_W-1:0]         cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [MUL_A_W+MUL_DIG_W-1:0] sum;

	// partial product of the low digit added into the running high half
	assign sum = {{MUL_DIG_W{1'b0}}, acc_q} + a_q * b_q[MUL_DIG_W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MUL_CNT_W'(MUL_NDIG - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: low product bits shift into the freed top of the multiplier register
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= sum[MUL_A_W+MUL_DIG_W-1:MUL_DIG_W];
			b_q   <= {sum[MUL_DIG_W-1:0], b_q[MUL_B_W-1:MUL_DIG_W]};
		end
	end

	assign done = done_q;
	assign prod = {acc_q, b_q};

endmodule

/* rtl/core/lrp_cordic.sv */
// Iterative rotation CORDIC: cosine and sine of a binary angle in Q30, one step per cycle.
`timescale 1ns / 1ps

module lrp_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lrp_pkg::ANGLE_W-1:0]       angle,
	output logic                              done,
	output logic signed [lrp_pkg::XY_W-1:0]   cosine,
	output logic signed [lrp_pkg::XY_W-1:0]   sine
);
	import lrp_pkg::*;

	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic                   flip_q;
	logic [ITER_W-1:0]      cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic signed [Z_W-1:0]  z_ext;
	logic signed [Z_W-1:0]  z_fold;
	logic                   flip_d;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [Z_W-1:0]  dz;

	// fold the angle into [-quarter, +quarter] turn; a half turn negates both results
	always_comb begin
		z_ext  = {{(Z_W-ANGLE_W){angle[ANGLE_W-1]}}, angle};
		z_fold = z_ext;
		flip_d = 1'b0;
		if (z_ext > QUARTER_TURN) begin
			z_fold = z_ext - HALF_TURN;
			flip_d = 1'b1;
		end else if (z_ext < -QUARTER_TURN) begin
			z_fold = z_ext + HALF_TURN;
			flip_d = 1'b1;
		end
	end

	// floor shifts for this step
	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign dz = atan_bam(cnt_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ITER_W'(CORDIC_ITERS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// micro-rotations
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_K;
			y_q    <= '0;
			z_q    <= z_fold;
			flip_q <= flip_d;
		end else if (busy_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - dz;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + dz;
			end
		end
	end

	assign done   = done_q;
	assign cosine = flip_q ? -x_q : x_q;
	assign sine   = flip_q ? -y_q : y_q;

endmodule
